### rtl/vss_pkg.sv
// Shared constants and types for the voxel sphere union pipeline.
package vss_pkg;

   // volume geometry
   localparam int VOLUME_SIDE = 512;
   localparam int POS_W       = $clog2(VOLUME_SIDE);

   // field and register widths
   localparam int DATA_W   = 32;
   localparam int RADIUS_W = 8;
   localparam int CENTER_W = 9;
   localparam int FRAC_W   = 16;
   localparam int APB_DW   = 32;
   localparam int ADDR_W   = 4;

   // arithmetic widths
   localparam int DIFF_W      = (POS_W > CENTER_W) ? POS_W : CENTER_W;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int ROOT_W      = 2 * ((SUM_W + 2 * FRAC_W + 3) / 4);
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 3;
   localparam int SQRT_STAGES = ROOT_W / 2;
   localparam int DIV_STAGES  = ROOT_W / 2;
   localparam int SPH_W       = DATA_W + 2;

   // last position on each axis
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(VOLUME_SIDE - 1);

   // one in Q16.16
   localparam logic [SPH_W-1:0] ONE_Q = SPH_W'(1) << FRAC_W;

   // register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RST   = RADIUS_W'(25);
   localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(250);
   localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(235);
   localparam logic [CENTER_W-1:0] CENTER_Z_RST = CENTER_W'(50);

   // register map, word index (byte address bits 3:2)
   typedef enum logic [1:0] {
      REG_RADIUS   = 2'd0,
      REG_CENTER_X = 2'd1,
      REG_CENTER_Y = 2'd2,
      REG_CENTER_Z = 2'd3
   } reg_index_type;

   // voxel value and flags riding along with the arithmetic
   typedef struct packed {
      logic signed [DATA_W-1:0] voxel;
      logic                     row_end;
      logic                     vol_end;
   } side_type;

endpackage

### rtl/vss_dist.sv
// Position counters and squared distance to the sphere center (three stages).
module vss_dist (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [vss_pkg::DATA_W-1:0] in_voxel,
   input  logic [vss_pkg::CENTER_W-1:0]      center_x,
   input  logic [vss_pkg::CENTER_W-1:0]      center_y,
   input  logic [vss_pkg::CENTER_W-1:0]      center_z,
   output logic                              out_valid,
   output logic [vss_pkg::SUM_W-1:0]         out_sum,
   output vss_pkg::side_type                 out_side
);

   logic [vss_pkg::POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [vss_pkg::POS_W-1:0] pos_x_in, pos_y_in, pos_z_in;

   logic                       valid1_ff, valid2_ff, valid3_ff;
   logic [vss_pkg::DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [vss_pkg::DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [vss_pkg::SQ_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic [vss_pkg::SUM_W-1:0]  sum_ff, sum_in;
   vss_pkg::side_type          side1_ff, side2_ff, side3_ff, side1_in;

   function automatic logic [vss_pkg::DIFF_W-1:0] abs_diff(
      input logic [vss_pkg::POS_W-1:0]    pos,
      input logic [vss_pkg::CENTER_W-1:0] ctr
   );
      logic [vss_pkg::DIFF_W-1:0] a;
      logic [vss_pkg::DIFF_W-1:0] b;
      a = vss_pkg::DIFF_W'(pos);
      b = vss_pkg::DIFF_W'(ctr);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // raster counters, z fastest, step on each input transfer
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (pos_z_ff == vss_pkg::POS_LAST) begin
         pos_z_in = '0;
         if (pos_y_ff == vss_pkg::POS_LAST) begin
            pos_y_in = '0;
            pos_x_in = (pos_x_ff == vss_pkg::POS_LAST) ? '0 : pos_x_ff + 1'b1;
         end else begin
            pos_y_in = pos_y_ff + 1'b1;
         end
      end else begin
         pos_z_in = pos_z_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (in_valid && advance) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   // stage 1: absolute differences and flags
   always_comb begin
      dx_in            = abs_diff(pos_x_ff, center_x);
      dy_in            = abs_diff(pos_y_ff, center_y);
      dz_in            = abs_diff(pos_z_ff, center_z);
      side1_in.voxel   = in_voxel;
      side1_in.row_end = (pos_z_ff == vss_pkg::POS_LAST);
      side1_in.vol_end = (pos_z_ff == vss_pkg::POS_LAST) &&
                         (pos_y_ff == vss_pkg::POS_LAST) &&
                         (pos_x_ff == vss_pkg::POS_LAST);
   end

   // stage 3 sum
   assign sum_in = vss_pkg::SUM_W'(sx_ff) + vss_pkg::SUM_W'(sy_ff) + vss_pkg::SUM_W'(sz_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // data path
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dz_ff    <= dz_in;
         side1_ff <= side1_in;
         sx_ff    <= vss_pkg::SQ_W'(dx_ff) * vss_pkg::SQ_W'(dx_ff);
         sy_ff    <= vss_pkg::SQ_W'(dy_ff) * vss_pkg::SQ_W'(dy_ff);
         sz_ff    <= vss_pkg::SQ_W'(dz_ff) * vss_pkg::SQ_W'(dz_ff);
         side2_ff <= side1_ff;
         sum_ff   <= sum_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side3_ff;

endmodule

### rtl/vss_sqrt.sv
// Pipelined integer square root of sum * 2^32, two root bits per stage.
module vss_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [vss_pkg::SUM_W-1:0]     in_sum,
   input  vss_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [vss_pkg::ROOT_W-1:0]    out_root,
   output vss_pkg::side_type             out_side
);

   localparam int N = vss_pkg::SQRT_STAGES;

   logic                       valid_ff [N];
   logic [vss_pkg::RAD_W-1:0]  rad_ff   [N];
   logic [vss_pkg::REM_W-1:0]  rem_ff   [N];
   logic [vss_pkg::ROOT_W-1:0] root_ff  [N];
   vss_pkg::side_type          side_ff  [N];

   genvar s;
   generate
      for (s = 0; s < N; s++) begin : g_stage
         logic                       valid_src;
         logic [vss_pkg::RAD_W-1:0]  rad_src, rad_in;
         logic [vss_pkg::REM_W-1:0]  rem_src, rem_in;
         logic [vss_pkg::ROOT_W-1:0] root_src, root_in;
         vss_pkg::side_type          side_src;

         if (s == 0) begin : g_first
            assign valid_src = in_valid;
            assign rad_src   = vss_pkg::RAD_W'(in_sum) << (2 * vss_pkg::FRAC_W);
            assign rem_src   = '0;
            assign root_src  = '0;
            assign side_src  = in_side;
         end else begin : g_next
            assign valid_src = valid_ff[s-1];
            assign rad_src   = rad_ff[s-1];
            assign rem_src   = rem_ff[s-1];
            assign root_src  = root_ff[s-1];
            assign side_src  = side_ff[s-1];
         end

         // two restoring root steps
         always_comb begin
            logic [vss_pkg::REM_W-1:0] trial;
            rad_in  = rad_src;
            rem_in  = rem_src;
            root_in = root_src;
            for (int k = 0; k < 2; k++) begin
               rem_in = {rem_in[vss_pkg::REM_W-3:0],
                         rad_in[vss_pkg::RAD_W-1:vss_pkg::RAD_W-2]};
               rad_in = rad_in << 2;
               trial  = {1'b0, root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[vss_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[vss_pkg::ROOT_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= valid_src;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rad_ff[s]  <= rad_in;
               rem_ff[s]  <= rem_in;
               root_ff[s] <= root_in;
               side_ff[s] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### rtl/vss_div.sv
// Pipelined restoring divide of the root by the radius, two quotient bits per stage.
module vss_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [vss_pkg::RADIUS_W-1:0]  divisor,
   input  logic                          in_valid,
   input  logic [vss_pkg::ROOT_W-1:0]    in_num,
   input  vss_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [vss_pkg::ROOT_W-1:0]    out_quot,
   output vss_pkg::side_type             out_side
);

   localparam int N = vss_pkg::DIV_STAGES;

   logic                         valid_ff [N];
   logic [vss_pkg::ROOT_W-1:0]   num_ff   [N];
   logic [vss_pkg::RADIUS_W-1:0] rem_ff   [N];
   vss_pkg::side_type            side_ff  [N];

   genvar s;
   generate
      for (s = 0; s < N; s++) begin : g_stage
         logic                         valid_src;
         logic [vss_pkg::ROOT_W-1:0]   num_src, num_in;
         logic [vss_pkg::RADIUS_W-1:0] rem_src, rem_in;
         vss_pkg::side_type            side_src;

         if (s == 0) begin : g_first
            assign valid_src = in_valid;
            assign num_src   = in_num;
            assign rem_src   = '0;
            assign side_src  = in_side;
         end else begin : g_next
            assign valid_src = valid_ff[s-1];
            assign num_src   = num_ff[s-1];
            assign rem_src   = rem_ff[s-1];
            assign side_src  = side_ff[s-1];
         end

         // dividend shifts out the top, quotient bits shift in at the bottom
         always_comb begin
            logic [vss_pkg::RADIUS_W:0] wide;
            num_in = num_src;
            rem_in = rem_src;
            for (int k = 0; k < 2; k++) begin
               wide   = {rem_in, num_in[vss_pkg::ROOT_W-1]};
               num_in = num_in << 1;
               if (wide >= {1'b0, divisor}) begin
                  wide      = wide - {1'b0, divisor};
                  num_in[0] = 1'b1;
               end
               rem_in = wide[vss_pkg::RADIUS_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= valid_src;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[s]  <= num_in;
               rem_ff[s]  <= rem_in;
               side_ff[s] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[N-1];
   assign out_quot  = num_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### rtl/voxel_sphere_sdf_union.sv
// Throughput: one voxel per cycle; the whole pipeline holds while a result waits untaken.
// The position counters are the only recurrence; squares, root and divide are staged.
// Reset (synchronous): counters to zero, registers to their defaults, pipeline emptied.
// Configuration is taken at once; no clearing pass follows reset.
module voxel_sphere_sdf_union (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [vss_pkg::DATA_W-1:0] req_voxel_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vss_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                              rsp_row_end,
   output logic                              rsp_volume_end,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [vss_pkg::ADDR_W-1:0]        paddr,
   input  logic [vss_pkg::APB_DW-1:0]        pwdata,
   output logic [vss_pkg::APB_DW-1:0]        prdata,
   output logic                              pready
);

   logic [vss_pkg::RADIUS_W-1:0] radius_ff;
   logic [vss_pkg::CENTER_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [vss_pkg::RADIUS_W-1:0] divisor;
   vss_pkg::reg_index_type       reg_index;
   logic                         reg_write;

   logic                         advance;
   logic                         dist_valid, root_valid, quot_valid;
   logic [vss_pkg::SUM_W-1:0]    dist_sum;
   logic [vss_pkg::ROOT_W-1:0]   root;
   logic [vss_pkg::ROOT_W-1:0]   quot;
   vss_pkg::side_type            dist_side, root_side, quot_side;

   logic signed [vss_pkg::SPH_W-1:0]  sphere_wide;
   logic signed [vss_pkg::DATA_W-1:0] sphere;
   logic signed [vss_pkg::DATA_W-1:0] merged_in;

   logic                              out_valid_ff;
   logic signed [vss_pkg::DATA_W-1:0] merged_ff;
   logic                              row_end_ff, vol_end_ff;

   // register port
   assign pready    = 1'b1;
   assign reg_index = vss_pkg::reg_index_type'(paddr[vss_pkg::ADDR_W-1:2]);
   assign reg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= vss_pkg::RADIUS_RST;
         center_x_ff <= vss_pkg::CENTER_X_RST;
         center_y_ff <= vss_pkg::CENTER_Y_RST;
         center_z_ff <= vss_pkg::CENTER_Z_RST;
      end else if (reg_write) begin
         unique case (reg_index)
            vss_pkg::REG_RADIUS:   radius_ff   <= pwdata[vss_pkg::RADIUS_W-1:0];
            vss_pkg::REG_CENTER_X: center_x_ff <= pwdata[vss_pkg::CENTER_W-1:0];
            vss_pkg::REG_CENTER_Y: center_y_ff <= pwdata[vss_pkg::CENTER_W-1:0];
            vss_pkg::REG_CENTER_Z: center_z_ff <= pwdata[vss_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         vss_pkg::REG_RADIUS:   prdata = vss_pkg::APB_DW'(radius_ff);
         vss_pkg::REG_CENTER_X: prdata = vss_pkg::APB_DW'(center_x_ff);
         vss_pkg::REG_CENTER_Y: prdata = vss_pkg::APB_DW'(center_y_ff);
         vss_pkg::REG_CENTER_Z: prdata = vss_pkg::APB_DW'(center_z_ff);
         default:               prdata = '0;
      endcase
   end

   // zero radius divides as one
   assign divisor = (radius_ff == '0) ? vss_pkg::RADIUS_W'(1) : radius_ff;

   // pipeline moves when the output register is empty or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   vss_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_voxel  (req_voxel_value),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .out_valid (dist_valid),
      .out_sum   (dist_sum),
      .out_side  (dist_side)
   );

   vss_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dist_valid),
      .in_sum    (dist_sum),
      .in_side   (dist_side),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   vss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (divisor),
      .in_valid  (root_valid),
      .in_num    (root),
      .in_side   (root_side),
      .out_valid (quot_valid),
      .out_quot  (quot),
      .out_side  (quot_side)
   );

   // subtract one, saturate, take the minimum with the input value
   always_comb begin
      sphere_wide = $signed(vss_pkg::SPH_W'(quot) - vss_pkg::ONE_Q);
      if (sphere_wide > $signed(vss_pkg::SPH_W'({1'b0, {(vss_pkg::DATA_W-1){1'b1}}}))) begin
         sphere = {1'b0, {(vss_pkg::DATA_W-1){1'b1}}};
      end else if (sphere_wide < $signed({{(vss_pkg::SPH_W-vss_pkg::DATA_W+1){1'b1}},
                                          {(vss_pkg::DATA_W-1){1'b0}}})) begin
         sphere = {1'b1, {(vss_pkg::DATA_W-1){1'b0}}};
      end else begin
         sphere = sphere_wide[vss_pkg::DATA_W-1:0];
      end
      merged_in = (quot_side.voxel < sphere) ? quot_side.voxel : sphere;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= quot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         merged_ff  <= merged_in;
         row_end_ff <= quot_side.row_end;
         vol_end_ff <= quot_side.vol_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_merged_value = merged_ff;
   assign rsp_row_end      = row_end_ff;
   assign rsp_volume_end   = vol_end_ff;

endmodule
